// ----- rtl/dsps_pkg.sv -----
// ----------------------------------------------------------------------------
// dsps_pkg - shared types and constants of the dual supply selector
// Phase codes, selection codes, register indexes, reset values and the
// structs passed between the configuration bank, the step logic and the top.
// ----------------------------------------------------------------------------
package dsps_pkg;

    // field widths
    localparam int LEVEL_W  = 10;
    localparam int DELAY_W  = 12;
    localparam int SEL_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // input item kinds
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    // selection codes
    localparam logic [SEL_W-1:0] SEL_NONE = 2'd0;
    localparam logic [SEL_W-1:0] SEL_ONE  = 2'd1;
    localparam logic [SEL_W-1:0] SEL_TWO  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRIORITY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_DLY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_DLY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_DLY  = 3'd4;

    // register reset values
    localparam logic [LEVEL_W-1:0] RST_THRESHOLD  = 10'd380;
    localparam logic [DELAY_W-1:0] RST_OFF_DLY    = 12'd250;
    localparam logic [DELAY_W-1:0] RST_SETTLE_DLY = 12'd500;
    localparam logic [DELAY_W-1:0] RST_HOLD_DLY   = 12'd250;

    // switching phases
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_OFF    = 2'd1,
        PH_SETTLE = 2'd2,
        PH_HOLD   = 2'd3
    } t_phase;

    typedef struct packed {
        logic [LEVEL_W-1:0] threshold;
        logic               second_first;
        logic [DELAY_W-1:0] off_dly;
        logic [DELAY_W-1:0] settle_dly;
        logic [DELAY_W-1:0] hold_dly;
    } t_cfg;

    typedef struct packed {
        logic [SEL_W-1:0]   sel;
        t_phase             phase;
        logic [DELAY_W-1:0] count;
        logic [1:0]         enables;
    } t_state;

endpackage

// ----- rtl/dsps_in_if.sv -----
// ----------------------------------------------------------------------------
// dsps_in_if - input channel of the dual supply selector
// Valid/ready channel carrying a sample pair or a millisecond tick.
// ----------------------------------------------------------------------------
interface dsps_in_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [dsps_pkg::LEVEL_W-1:0]  supply_one_level;
    logic [dsps_pkg::LEVEL_W-1:0]  supply_two_level;

    modport source (output valid, mode, supply_one_level, supply_two_level, input ready);
    modport sink   (input valid, mode, supply_one_level, supply_two_level, output ready);
endinterface

// ----- rtl/dsps_out_if.sv -----
// ----------------------------------------------------------------------------
// dsps_out_if - result channel of the dual supply selector
// Valid/ready channel carrying enables, selection and busy flag.
// ----------------------------------------------------------------------------
interface dsps_out_if;
    logic                        valid;
    logic                        ready;
    logic                        enable_one;
    logic                        enable_two;
    logic [dsps_pkg::SEL_W-1:0]  chosen_supply;
    logic                        busy_res;

    modport source (output valid, enable_one, enable_two, chosen_supply, busy_res,
                    input ready);
    modport sink   (input valid, enable_one, enable_two, chosen_supply, busy_res,
                    output ready);
endinterface

// ----- rtl/dsps_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// dsps_cfg_regs - configuration register bank
// Holds threshold, priority and the three delays; writes to unknown
// indexes are dropped.
// ----------------------------------------------------------------------------
module dsps_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dsps_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [dsps_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output dsps_pkg::t_cfg                    o_cfg
);

    dsps_pkg::t_cfg r_cfg;

    // register write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold    <= dsps_pkg::RST_THRESHOLD;
            r_cfg.second_first <= 1'b0;
            r_cfg.off_dly      <= dsps_pkg::RST_OFF_DLY;
            r_cfg.settle_dly   <= dsps_pkg::RST_SETTLE_DLY;
            r_cfg.hold_dly     <= dsps_pkg::RST_HOLD_DLY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dsps_pkg::REG_THRESHOLD:  r_cfg.threshold <= i_cfg_data[dsps_pkg::LEVEL_W-1:0];
                dsps_pkg::REG_PRIORITY:   r_cfg.second_first <= i_cfg_data[0];
                dsps_pkg::REG_OFF_DLY:    r_cfg.off_dly <= i_cfg_data[dsps_pkg::DELAY_W-1:0];
                dsps_pkg::REG_SETTLE_DLY: r_cfg.settle_dly <= i_cfg_data[dsps_pkg::DELAY_W-1:0];
                dsps_pkg::REG_HOLD_DLY:   r_cfg.hold_dly <= i_cfg_data[dsps_pkg::DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/dsps_step.sv -----
// ----------------------------------------------------------------------------
// dsps_step - next-state logic for one transaction
// Priority pick on samples, tick countdown, and the chain of phase ends
// that can complete within a single transaction when delays are zero.
// ----------------------------------------------------------------------------
module dsps_step (
    input  dsps_pkg::t_state                  i_state,
    input  dsps_pkg::t_cfg                    i_cfg,
    input  logic                              i_mode,
    input  logic [dsps_pkg::LEVEL_W-1:0]      i_lvl_one,
    input  logic [dsps_pkg::LEVEL_W-1:0]      i_lvl_two,
    output dsps_pkg::t_state                  o_state
);

    localparam int N_PHASE_ENDS = 3;

    // end the current wait phase if its count has run out
    function automatic dsps_pkg::t_state end_phase(dsps_pkg::t_state s, dsps_pkg::t_cfg c);
        dsps_pkg::t_state r;
        r = s;
        if (s.count == '0) begin
            case (s.phase)
                dsps_pkg::PH_OFF: begin
                    if (s.sel == dsps_pkg::SEL_NONE) begin
                        r.phase = dsps_pkg::PH_IDLE;
                    end else begin
                        r.phase = dsps_pkg::PH_SETTLE;
                        r.count = c.settle_dly;
                    end
                end
                dsps_pkg::PH_SETTLE: begin
                    r.enables = {s.sel == dsps_pkg::SEL_TWO, s.sel == dsps_pkg::SEL_ONE};
                    r.phase   = dsps_pkg::PH_HOLD;
                    r.count   = c.hold_dly;
                end
                dsps_pkg::PH_HOLD: r.phase = dsps_pkg::PH_IDLE;
                default: ;
            endcase
        end
        return r;
    endfunction

    logic             p_one;
    logic             p_two;
    logic [dsps_pkg::SEL_W-1:0] pick;
    dsps_pkg::t_state s_entry;
    dsps_pkg::t_state s_chain [N_PHASE_ENDS+1];

    // presence and priority pick
    always_comb begin
        p_one = i_lvl_one >= i_cfg.threshold;
        p_two = i_lvl_two >= i_cfg.threshold;
        pick  = dsps_pkg::SEL_NONE;
        if (i_cfg.second_first) begin
            if (p_two)      pick = dsps_pkg::SEL_TWO;
            else if (p_one) pick = dsps_pkg::SEL_ONE;
        end else begin
            if (p_one)      pick = dsps_pkg::SEL_ONE;
            else if (p_two) pick = dsps_pkg::SEL_TWO;
        end
    end

    // start a switch on a new pick while idle, or count a tick down
    always_comb begin
        s_entry = i_state;
        if (i_mode == dsps_pkg::MODE_SAMPLE) begin
            if (i_state.phase == dsps_pkg::PH_IDLE && pick != i_state.sel) begin
                s_entry.sel     = pick;
                s_entry.enables = 2'b00;
                s_entry.phase   = dsps_pkg::PH_OFF;
                s_entry.count   = i_cfg.off_dly;
            end
        end else if (i_state.phase != dsps_pkg::PH_IDLE && i_state.count != '0) begin
            s_entry.count = i_state.count - 1'b1;
        end
    end

    // off, settle and hold may all expire in one transaction
    always_comb begin
        s_chain[0] = s_entry;
        for (int k = 0; k < N_PHASE_ENDS; k++) begin
            s_chain[k+1] = end_phase(s_chain[k], i_cfg);
        end
    end

    assign o_state = s_chain[N_PHASE_ENDS];

endmodule

// ----- rtl/dual_supply_priority_selector_core.sv -----
// ----------------------------------------------------------------------------
// dual_supply_priority_selector_core - break-before-make supply selector
// Usage: transactions on i_in are either a pair of supply levels in
// centivolts (mode 0) or a one millisecond tick (mode 1). Every input
// transaction yields exactly one result transaction on o_out carrying both
// enables, the current selection and a busy flag, all as they stand after
// that transaction. Registers are written through i_cfg_we / i_cfg_idx /
// i_cfg_data while no transaction is in flight.
// Path: a transaction passes the input register, then the state and result
// register, from which the result is taken on o_out.
// Throughput: one transaction per cycle unless o_out.ready stalls; the
// selection, countdown and phase chain are compare and counter logic.
// Reset (synchronous, active low): registers take their default values,
// selection none, both enables off, idle, no result pending.
// Stall: when o_out.ready is low the result is held; one further
// transaction is taken into the input register, then i_in.ready drops.
// ----------------------------------------------------------------------------
module dual_supply_priority_selector_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    dsps_in_if.sink                           i_in,
    dsps_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic [dsps_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [dsps_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    dsps_pkg::t_cfg   cfg;
    dsps_pkg::t_state r_state;
    dsps_pkg::t_state n_state;

    logic                         r_s1_valid;
    logic                         r_s1_mode;
    logic [dsps_pkg::LEVEL_W-1:0] r_s1_lvl_one;
    logic [dsps_pkg::LEVEL_W-1:0] r_s1_lvl_two;
    logic                         r_out_valid;
    logic                         out_load;

    // configuration bank
    dsps_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // per-transaction state update
    dsps_step u_step (
        .i_state   (r_state),
        .i_cfg     (cfg),
        .i_mode    (r_s1_mode),
        .i_lvl_one (r_s1_lvl_one),
        .i_lvl_two (r_s1_lvl_two),
        .o_state   (n_state)
    );

    // handshake control
    assign out_load   = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_s1_valid || out_load;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_s1_mode    <= i_in.mode;
            r_s1_lvl_one <= i_in.supply_one_level;
            r_s1_lvl_two <= i_in.supply_two_level;
        end
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid     <= 1'b0;
            r_state.sel     <= dsps_pkg::SEL_NONE;
            r_state.phase   <= dsps_pkg::PH_IDLE;
            r_state.count   <= '0;
            r_state.enables <= 2'b00;
        end else if (out_load) begin
            r_out_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_state <= n_state;
            end
        end
    end

    // result fields
    assign o_out.valid         = r_out_valid;
    assign o_out.enable_one    = r_state.enables[0];
    assign o_out.enable_two    = r_state.enables[1];
    assign o_out.chosen_supply = r_state.sel;
    assign o_out.busy_res      = r_state.phase != dsps_pkg::PH_IDLE;

`ifndef SYNTHESIS
    // an enable is only ever raised for the selected supply
    a_enable_matches_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_state.enables[0] || r_state.sel == dsps_pkg::SEL_ONE) &&
        (!r_state.enables[1] || r_state.sel == dsps_pkg::SEL_TWO))
        else $error("enable raised for a supply that is not selected");

    // break before make: both enables off during off and settle waits
    a_break_before_make: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == dsps_pkg::PH_OFF || r_state.phase == dsps_pkg::PH_SETTLE)
        |-> r_state.enables == 2'b00)
        else $error("enable high during off or settle wait");

    // when idle the enables reflect the selection exactly
    a_idle_enables: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == dsps_pkg::PH_IDLE |->
        r_state.enables == {r_state.sel == dsps_pkg::SEL_TWO,
                            r_state.sel == dsps_pkg::SEL_ONE})
        else $error("idle enables disagree with selection");

    // state only moves when a transaction passes into the result register
    a_state_moves_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(out_load && r_s1_valid) |=> $stable(r_state))
        else $error("state changed without a transaction");
`endif

endmodule
